@@ rtl/bale_pkg.sv @@
// Shared types and constants for the bounded array list engine.
package bale_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;
  localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd6;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_INDEX = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_word;
    logic [CNT_W-1:0]         count;
    logic [ST_W-1:0]          status;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_SCAN,
    S_DONE
  } seq_state_t;

endpackage

@@ rtl/bale_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module bale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bale_seq.sv @@
// Command sequencer: walks the list memory for each command and builds the result word.
module bale_seq #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bale_pkg::in_t              in_data,
  output logic                       res_valid,
  output bale_pkg::out_t             res,
  input  logic                       res_take,
  output logic                       mem_we,
  output logic [$clog2(DEPTH)-1:0]   mem_waddr,
  output logic [bale_pkg::WORD_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [$clog2(DEPTH)-1:0]   mem_raddr,
  input  logic [bale_pkg::WORD_W-1:0] mem_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > bale_pkg::POS_W) ? CW : bale_pkg::POS_W;

  bale_pkg::seq_state_t state, state_next;
  logic [CW-1:0]                fill, fill_next;
  logic [CW-1:0]                idx, idx_next;
  logic [CW-1:0]                wr_idx, wr_idx_next;
  logic                         pend, pend_next;
  logic [AW-1:0]                pend_addr, pend_addr_next;
  logic [bale_pkg::WORD_W-1:0]  op_val, op_val_next;
  bale_pkg::out_t               res_next;
  logic                         accept;
  logic                         is_full;
  logic                         pos_ok;

  assign in_stall  = (state != bale_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign res_valid = (state == bale_pkg::S_DONE);
  assign is_full   = (fill == CW'(DEPTH));
  assign pos_ok    = (XW'(in_data.position) < XW'(fill));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bale_pkg::S_IDLE;
      fill  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    wr_idx    <= wr_idx_next;
    pend_addr <= pend_addr_next;
    op_val    <= op_val_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    idx_next       = idx;
    wr_idx_next    = wr_idx;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    op_val_next    = op_val;
    res_next       = res;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = op_val;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    unique case (state)
      bale_pkg::S_IDLE: begin
        if (accept) begin
          op_val_next        = in_data.value;
          res_next.read_word = '0;
          res_next.count     = bale_pkg::CNT_W'(fill);
          res_next.status    = bale_pkg::ST_OK;
          state_next         = bale_pkg::S_DONE;
          unique case (in_data.command)
            bale_pkg::CMD_PUSH_BACK: begin
              if (is_full) begin
                res_next.status = bale_pkg::ST_FULL;
              end else begin
                mem_we         = 1'b1;
                mem_waddr      = AW'(fill);
                mem_wdata      = in_data.value;
                fill_next      = fill + CW'(1);
                res_next.count = bale_pkg::CNT_W'(fill + CW'(1));
              end
            end
            bale_pkg::CMD_PUSH_FRONT: begin
              if (is_full) begin
                res_next.status = bale_pkg::ST_FULL;
              end else begin
                idx_next   = fill;
                pend_next  = 1'b0;
                state_next = bale_pkg::S_SHIFT;
              end
            end
            bale_pkg::CMD_POP_BACK: begin
              if (fill != '0) begin
                fill_next      = fill - CW'(1);
                res_next.count = bale_pkg::CNT_W'(fill - CW'(1));
              end
            end
            bale_pkg::CMD_REMOVE: begin
              idx_next    = '0;
              wr_idx_next = '0;
              pend_next   = 1'b0;
              state_next  = bale_pkg::S_SCAN;
            end
            bale_pkg::CMD_CLEAR: begin
              fill_next      = '0;
              res_next.count = '0;
            end
            bale_pkg::CMD_READ: begin
              if (pos_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(in_data.position);
                state_next = bale_pkg::S_READ;
              end else begin
                res_next.status = bale_pkg::ST_INDEX;
              end
            end
            bale_pkg::CMD_WRITE: begin
              if (pos_ok) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_data.position);
                mem_wdata = in_data.value;
              end else begin
                res_next.status = bale_pkg::ST_INDEX;
              end
            end
            default: begin
            end
          endcase
        end
      end

      bale_pkg::S_READ: begin
        res_next.read_word = mem_rdata;
        state_next         = bale_pkg::S_DONE;
      end

      // Walk downward: read entry k, write it to k+1 in the following cycle. The write
      // always lands above the next read, so no forwarding is needed.
      bale_pkg::S_SHIFT: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr + AW'(1);
          mem_wdata = mem_rdata;
        end
        if (idx != '0) begin
          mem_re         = 1'b1;
          mem_raddr      = AW'(idx - CW'(1));
          pend_addr_next = AW'(idx - CW'(1));
          idx_next       = idx - CW'(1);
          pend_next      = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            mem_we         = 1'b1;
            mem_waddr      = '0;
            mem_wdata      = op_val;
            fill_next      = fill + CW'(1);
            res_next.count = bale_pkg::CNT_W'(fill + CW'(1));
            state_next     = bale_pkg::S_DONE;
          end
        end
      end

      // Walk upward compacting survivors; write index never passes read index.
      bale_pkg::S_SCAN: begin
        if (pend && (mem_rdata != op_val)) begin
          mem_we      = 1'b1;
          mem_waddr   = AW'(wr_idx);
          mem_wdata   = mem_rdata;
          wr_idx_next = wr_idx + CW'(1);
        end
        if (idx < fill) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx);
          idx_next  = idx + CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            fill_next      = wr_idx;
            res_next.count = bale_pkg::CNT_W'(wr_idx);
            state_next     = bale_pkg::S_DONE;
          end
        end
      end

      bale_pkg::S_DONE: begin
        if (res_take) begin
          state_next = bale_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bale_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/bounded_array_list_engine_top.sv @@
// Push back, pop, clear, write and refused commands go straight from accept to the result
// register; read passes through S_READ to pick up the memory read data; push front and
// remove-by-value walk the list through the single-port-pair list memory, one entry
// per cycle. One command in flight; the next is taken while the previous result waits
// in out_data.
// Reset (rst, synchronous) empties the list and the handshakes; memory is not cleared.
module bounded_array_list_engine_top #(
  parameter int DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bale_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bale_pkg::out_t out_data
);

  localparam int AW = $clog2(DEPTH);

  logic                        res_valid;
  logic                        res_take;
  bale_pkg::out_t              res;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [bale_pkg::WORD_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [bale_pkg::WORD_W-1:0] mem_rdata;

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

  bale_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bale_ram #(
    .WIDTH(bale_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ rtl/bale_check.sv @@
// Port-level checker for the bounded array list engine, bound to the top level.
module bale_check #(
  parameter int DEPTH = 64
) (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input bale_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("handshake not idle after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH >= 128) || (int'(out_data.count) <= DEPTH))
    else $error("count beyond capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == bale_pkg::ST_FULL)
      |-> out_data.count == bale_pkg::CNT_W'(DEPTH))
    else $error("full status with list not full");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != bale_pkg::ST_OK) |-> out_data.read_word == '0)
    else $error("read word nonzero on refused command");

endmodule

bind bounded_array_list_engine_top bale_check #(.DEPTH(DEPTH)) u_bale_check (.*);

@@ sim/tb_bounded_array_list_engine_top.sv @@
// Self-checking testbench for the list engine: queued stimulus, shadow list, reply check.
module tb_bounded_array_list_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 64;
  localparam int QUIET_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1550;
  localparam logic [bale_pkg::CMD_W-1:0] CMD_SPARE = 3'd7;

  typedef struct packed {
    logic          drain;
    bale_pkg::in_t word;
  } queued_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  bale_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bale_pkg::out_t out_data;

  // shadow of the list, used first to plan stimulus and then to predict replies
  logic [bale_pkg::WORD_W-1:0] shadow_slots [LIST_DEPTH];
  int held = 0;

  queued_cmd_t cmd_queue [$];
  queued_cmd_t cmd_next;
  bale_pkg::out_t list_reply_q [$];
  bale_pkg::out_t reply_want;
  int errors = 0;
  int n_sent = 0;
  int quiet_cycles = 0;
  logic calm;
  logic [bale_pkg::WORD_W-1:0] value_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                  32'h7FFF_FFFF, 32'h8000_0000,
                                                  32'h0000_0001, 32'h5A5A_5A5A};

  bounded_array_list_engine_top #(.DEPTH(LIST_DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // no random idling on either side across this stretch of accepted words
  assign calm = (n_sent >= 600) && (n_sent < 900);

  function automatic bale_pkg::out_t list_apply(input bale_pkg::in_t c);
    bale_pkg::out_t r;
    int k;
    int j;
    r = '0;
    r.status = bale_pkg::ST_OK;
    case (c.command)
      bale_pkg::CMD_PUSH_BACK: begin
        if (held >= LIST_DEPTH) begin
          r.status = bale_pkg::ST_FULL;
        end else begin
          shadow_slots[held] = c.value;
          held++;
        end
      end
      bale_pkg::CMD_PUSH_FRONT: begin
        if (held >= LIST_DEPTH) begin
          r.status = bale_pkg::ST_FULL;
        end else begin
          for (k = held; k > 0; k--) shadow_slots[k] = shadow_slots[k-1];
          shadow_slots[0] = c.value;
          held++;
        end
      end
      bale_pkg::CMD_POP_BACK: begin
        if (held > 0) held--;
      end
      bale_pkg::CMD_REMOVE: begin
        j = 0;
        for (k = 0; k < held; k++) begin
          if (shadow_slots[k] != c.value) begin
            shadow_slots[j] = shadow_slots[k];
            j++;
          end
        end
        held = j;
      end
      bale_pkg::CMD_CLEAR: begin
        held = 0;
      end
      bale_pkg::CMD_READ: begin
        if (int'(c.position) < held) r.read_word = shadow_slots[c.position];
        else r.status = bale_pkg::ST_INDEX;
      end
      bale_pkg::CMD_WRITE: begin
        if (int'(c.position) < held) shadow_slots[c.position] = c.value;
        else r.status = bale_pkg::ST_INDEX;
      end
      default: ;
    endcase
    r.count = bale_pkg::CNT_W'(held);
    return r;
  endfunction

  function automatic bale_pkg::in_t make_cmd(input logic [bale_pkg::CMD_W-1:0] op,
                                             input logic [bale_pkg::WORD_W-1:0] v,
                                             input logic [bale_pkg::POS_W-1:0] p);
    bale_pkg::in_t w;
    w.command = op;
    w.value = v;
    w.position = p;
    return w;
  endfunction

  function automatic logic [bale_pkg::WORD_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 40) return value_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // queue a word and advance the planning copy of the list
  task automatic plan(input bale_pkg::in_t w);
    queued_cmd_t q;
    q.drain = (cmd_queue.size() % 400 == 399);
    q.word = w;
    cmd_queue.push_back(q);
    void'(list_apply(w));
  endtask

  function automatic logic [bale_pkg::POS_W-1:0] pick_pos();
    if (held > 0 && $urandom_range(0, 99) < 80) begin
      return bale_pkg::POS_W'($urandom_range(0, held - 1));
    end
    return bale_pkg::POS_W'($urandom_range(0, 63));
  endfunction

  function automatic bale_pkg::in_t random_cmd();
    int roll;
    logic [bale_pkg::WORD_W-1:0] v;
    roll = $urandom_range(0, 99);
    v = pick_value();
    if (roll < 20) return make_cmd(bale_pkg::CMD_PUSH_BACK, v, bale_pkg::POS_W'($urandom));
    if (roll < 35) return make_cmd(bale_pkg::CMD_PUSH_FRONT, v, bale_pkg::POS_W'($urandom));
    if (roll < 45) return make_cmd(bale_pkg::CMD_POP_BACK, v, bale_pkg::POS_W'($urandom));
    if (roll < 55) begin
      // half the time, remove a value that is actually held
      if (held > 0 && $urandom_range(0, 1) == 1) v = shadow_slots[$urandom_range(0, held - 1)];
      return make_cmd(bale_pkg::CMD_REMOVE, v, bale_pkg::POS_W'($urandom));
    end
    if (roll < 58) return make_cmd(bale_pkg::CMD_CLEAR, v, bale_pkg::POS_W'($urandom));
    if (roll < 78) return make_cmd(bale_pkg::CMD_READ, v, pick_pos());
    if (roll < 93) return make_cmd(bale_pkg::CMD_WRITE, v, pick_pos());
    if (roll < 95) return make_cmd(CMD_SPARE, v, bale_pkg::POS_W'($urandom));
    return make_cmd(bale_pkg::CMD_W'($urandom_range(0, 7)), $urandom,
                    bale_pkg::POS_W'($urandom));
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        list_reply_q.push_back(list_apply(in_data));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_queue.size() != 0 &&
            !(cmd_queue[0].drain && list_reply_q.size() != 0) &&
            !(!calm && $urandom_range(0, 99) < 13)) begin
          cmd_next = cmd_queue.pop_front();
          in_valid <= 1'b1;
          in_data <= cmd_next.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (list_reply_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $realtime, out_data);
          errors++;
        end else begin
          reply_want = list_reply_q.pop_front();
          if (out_data.read_word !== reply_want.read_word) begin
            $display("%0t: read_word mismatch, expected %h, actual %h", $realtime,
                     reply_want.read_word, out_data.read_word);
            errors++;
          end
          if (out_data.count !== reply_want.count) begin
            $display("%0t: count mismatch, expected %0d, actual %0d", $realtime,
                     reply_want.count, out_data.count);
            errors++;
          end
          if (out_data.status !== reply_want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $realtime,
                     reply_want.status, out_data.status);
            errors++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 13);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    foreach (shadow_slots[k]) shadow_slots[k] = '0;

    // empty list: bad index, pop and remove do nothing, spare command
    plan(make_cmd(bale_pkg::CMD_READ, 32'h0, 6'd0));
    plan(make_cmd(bale_pkg::CMD_POP_BACK, 32'h0, 6'd0));
    plan(make_cmd(bale_pkg::CMD_REMOVE, 32'h5, 6'd0));
    plan(make_cmd(CMD_SPARE, 32'h0, 6'd0));
    plan(make_cmd(bale_pkg::CMD_WRITE, 32'h1234_5678, 6'd0));
    plan(make_cmd(bale_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF, 6'd0));
    plan(make_cmd(bale_pkg::CMD_PUSH_BACK, 32'h8000_0000, 6'd63));
    plan(make_cmd(bale_pkg::CMD_PUSH_FRONT, 32'h0, 6'd0));
    plan(make_cmd(bale_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF, 6'd0));
    plan(make_cmd(bale_pkg::CMD_READ, 32'h0, 6'd0));
    plan(make_cmd(bale_pkg::CMD_READ, 32'h0, 6'd1));
    plan(make_cmd(bale_pkg::CMD_READ, 32'h0, 6'd2));
    plan(make_cmd(bale_pkg::CMD_READ, 32'hFFFF_FFFF, 6'd3));
    plan(make_cmd(bale_pkg::CMD_READ, 32'h0, 6'd63));
    plan(make_cmd(bale_pkg::CMD_WRITE, 32'h5555_5555, 6'd3));
    plan(make_cmd(bale_pkg::CMD_WRITE, 32'hAAAA_AAAA, 6'd63));
    plan(make_cmd(bale_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF, 6'd0));
    plan(make_cmd(bale_pkg::CMD_REMOVE, 32'h1234_0000, 6'd0));
    plan(make_cmd(bale_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 6'd0));
    plan(make_cmd(bale_pkg::CMD_READ, 32'h0, 6'd0));
    plan(make_cmd(bale_pkg::CMD_READ, 32'h0, 6'd2));
    plan(make_cmd(bale_pkg::CMD_POP_BACK, 32'h0, 6'd0));
    plan(make_cmd(bale_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 6'd63));
    plan(make_cmd(bale_pkg::CMD_READ, 32'h0, 6'd0));
    plan(make_cmd(CMD_SPARE, 32'hFFFF_FFFF, 6'd63));

    while (cmd_queue.size() < 25 + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        // fill to the top, bounce off the full list, then work on it
        while (held < LIST_DEPTH) begin
          plan(make_cmd($urandom_range(0, 1) ? bale_pkg::CMD_PUSH_FRONT
                                             : bale_pkg::CMD_PUSH_BACK,
                        pick_value(), bale_pkg::POS_W'($urandom)));
        end
        plan(make_cmd(bale_pkg::CMD_PUSH_BACK, pick_value(), bale_pkg::POS_W'($urandom)));
        plan(make_cmd(bale_pkg::CMD_PUSH_FRONT, pick_value(), bale_pkg::POS_W'($urandom)));
        plan(make_cmd(bale_pkg::CMD_READ, 32'h0, 6'd63));
        plan(make_cmd(bale_pkg::CMD_WRITE, pick_value(), 6'd63));
        plan(make_cmd(bale_pkg::CMD_READ, 32'h0, 6'd63));
        repeat (6) plan(random_cmd());
      end else begin
        repeat (25) plan(random_cmd());
      end
    end

    // planning done: return the shadow to its reset state for prediction
    held = 0;
    foreach (shadow_slots[k]) shadow_slots[k] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (cmd_queue.size() != 0 || in_valid || list_reply_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bale_pkg.sv
rtl/bale_ram.sv
rtl/bale_seq.sv
rtl/bounded_array_list_engine_top.sv
rtl/bale_check.sv
sim/tb_bounded_array_list_engine_top.sv
